FILE: rtl/ttcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_pkg
// Types and constants shared by the text terminal cursor control block.
// ----------------------------------------------------------------------------
package ttcc_pkg;

    // Screen limits and tab spacing.
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;
    localparam int TAB_STOP = 8;
    localparam int COL_LIM  = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int ROW_LIM  = (MAX_ROWS < 128) ? MAX_ROWS : 128;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_FG      = 2'd2;
    localparam logic [1:0] CFG_BG      = 2'd3;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Reset values of the screen size registers.
    localparam logic [8:0] COLS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    // Command codes of an input word.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Operation codes of a result word.
    localparam logic [1:0] OP_DRAW   = 2'd0;
    localparam logic [1:0] OP_SCROLL = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Character codes with special handling.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [7:0] set_col;
        logic [6:0] set_row;
    } t_in_word;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] cell_col;
        logic [6:0] cell_row;
        logic [6:0] glyph_code;
        logic       last;
    } t_out_word;

    // Results of one input word: a first operation and an optional scroll.
    typedef struct packed {
        logic [1:0] first_op;
        logic [7:0] col;
        logic [6:0] row;
        logic [6:0] glyph;
        logic       has_scroll;
    } t_rec;

endpackage

FILE: rtl/ttcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_step
// Cursor update for one input word and the results that it produces.
// ----------------------------------------------------------------------------
module ttcc_step (
    input  ttcc_pkg::t_in_word i_word,
    input  logic [7:0]         i_cur_col,
    input  logic [6:0]         i_cur_row,
    input  logic [8:0]         i_cols,
    input  logic [7:0]         i_rows,
    output logic [7:0]         o_next_col,
    output logic [6:0]         o_next_row,
    output logic               o_rec_valid,
    output ttcc_pkg::t_rec     o_rec
);
    import ttcc_pkg::*;

    logic [8:0] x;
    logic [7:0] y;
    logic [8:0] x_draw;
    logic       draw;
    logic [7:0] glyph;
    logic       scroll;
    logic [8:0] last_col;
    logic [7:0] last_row;

    always_comb begin
        last_col    = i_cols - 9'd1;
        last_row    = i_rows - 8'd1;
        x           = {1'b0, i_cur_col};
        y           = {1'b0, i_cur_row};
        x_draw      = x;
        draw        = 1'b0;
        glyph       = CH_SPACE;
        scroll      = 1'b0;
        o_next_col  = i_cur_col;
        o_next_row  = i_cur_row;
        o_rec_valid = 1'b0;
        o_rec       = '0;

        case (i_word.command)
            CMD_SET: begin
                o_next_col = ({1'b0, i_word.set_col} > last_col) ? last_col[7:0]
                                                                  : i_word.set_col;
                o_next_row = ({1'b0, i_word.set_row} > last_row) ? last_row[6:0]
                                                                  : i_word.set_row;
            end
            CMD_CLEAR: begin
                o_next_col        = '0;
                o_next_row        = '0;
                o_rec_valid       = 1'b1;
                o_rec.first_op    = OP_CLEAR;
            end
            CMD_PUT: begin
                case (i_word.char_code)
                    CH_LF: begin
                        y = y + 8'd1;
                        x = '0;
                    end
                    CH_CR: begin
                        x = '0;
                    end
                    CH_BS: begin
                        if (x != '0) begin
                            x      = x - 9'd1;
                            x_draw = x;
                            draw   = (x < i_cols) && (y < i_rows);
                            glyph  = CH_SPACE;
                        end
                    end
                    CH_TAB: begin
                        x = 9'((x / 9'(TAB_STOP) + 9'd1) * 9'(TAB_STOP));
                    end
                    default: begin
                        x_draw = x;
                        draw   = (x < i_cols) && (y < i_rows);
                        glyph  = (i_word.char_code < PRINT_LO || i_word.char_code > PRINT_HI)
                                 ? CH_QMARK : i_word.char_code;
                        x      = x + 9'd1;
                    end
                endcase

                // Wrap past the right edge, then scroll off the bottom.
                if (x >= i_cols) begin
                    x = '0;
                    y = y + 8'd1;
                end
                if (y >= i_rows) begin
                    scroll = 1'b1;
                    y      = last_row;
                end

                o_next_col  = x[7:0];
                o_next_row  = y[6:0];
                o_rec_valid = draw || scroll;
                if (draw) begin
                    o_rec.first_op   = OP_DRAW;
                    o_rec.col        = x_draw[7:0];
                    o_rec.row        = i_cur_row;
                    o_rec.glyph      = glyph[6:0];
                    o_rec.has_scroll = scroll;
                end else begin
                    o_rec.first_op   = OP_SCROLL;
                end
            end
            default: begin
                // Undefined command: nothing changes.
                o_rec_valid = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/text_terminal_cursor_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_control
// Cursor logic of a character-cell text terminal: turns command words into
// draw, scroll and clear operations for a renderer.
// ----------------------------------------------------------------------------
// A command word is registered on acceptance and then worked out against the
// cursor, and its results are loaded into the output register once that
// register is free or hands out its last word. The block takes one word per
// cycle as long as each word gives at most one result and the output is not
// stalled; a put character that both draws and scrolls holds the output
// register for a second result word, since the output register hands out one
// result word per cycle while the receiver is ready. Words that give no result
// (set cursor, cursor moves) leave the output register empty. The colors are
// meant for the renderer and are not held in this block.
module text_terminal_cursor_control (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ttcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ttcc_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ttcc_pkg::t_out_word                 o_out_word
);
    import ttcc_pkg::*;

    logic [8:0] r_cols;
    logic [7:0] r_rows;
    logic [7:0] r_cur_col;
    logic [6:0] r_cur_row;
    logic       r_a_valid;
    t_in_word   r_a;
    logic       r_b_valid;
    logic       r_b_phase;
    t_rec       r_b;

    logic [8:0] cfg_cols;
    logic [7:0] cfg_rows;
    logic [7:0] n_cur_col;
    logic [6:0] n_cur_row;
    logic       rec_valid;
    t_rec       rec;
    logic       b_pop;
    logic       b_done;
    logic       a_adv;

    ttcc_step u_step (
        .i_word      (r_a),
        .i_cur_col   (r_cur_col),
        .i_cur_row   (r_cur_row),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .o_next_col  (n_cur_col),
        .o_next_row  (n_cur_row),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    // Screen sizes are held already clamped to their legal range.
    always_comb begin
        cfg_cols = i_cfg_data[8:0];
        if (cfg_cols == '0) begin
            cfg_cols = 9'd1;
        end else if (cfg_cols > 9'(COL_LIM)) begin
            cfg_cols = 9'(COL_LIM);
        end
        cfg_rows = i_cfg_data[7:0];
        if (cfg_rows == '0) begin
            cfg_rows = 8'd1;
        end else if (cfg_rows > 8'(ROW_LIM)) begin
            cfg_rows = 8'(ROW_LIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_cols <= cfg_cols;
                CFG_ROWS:    r_rows <= cfg_rows;
                default: begin
                end
            endcase
        end
    end

    // The output register finishes a record on its last word.
    assign b_pop      = r_b_valid && i_out_ready;
    assign b_done     = b_pop && (r_b_phase || !r_b.has_scroll);
    assign a_adv      = r_a_valid && (!r_b_valid || b_done);
    assign o_in_ready = !r_a_valid || a_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_phase <= 1'b0;
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (a_adv) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
            end
            if (a_adv) begin
                r_b_valid <= rec_valid;
                r_b_phase <= 1'b0;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
                r_b_phase <= 1'b0;
            end else if (b_pop) begin
                r_b_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= i_in_word;
        end
        if (a_adv) begin
            r_b <= rec;
        end
    end

    always_comb begin
        o_out_valid = r_b_valid;
        if (r_b_phase) begin
            o_out_word.operation  = OP_SCROLL;
            o_out_word.cell_col   = '0;
            o_out_word.cell_row   = '0;
            o_out_word.glyph_code = '0;
            o_out_word.last       = 1'b1;
        end else begin
            o_out_word.operation  = r_b.first_op;
            o_out_word.cell_col   = r_b.col;
            o_out_word.cell_row   = r_b.row;
            o_out_word.glyph_code = r_b.glyph;
            o_out_word.last       = !r_b.has_scroll;
        end
    end

endmodule

FILE: bench/tb_text_terminal_cursor_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_terminal_cursor_control
// Self-checking bench for the terminal cursor block. A queue of command words
// feeds a valid/ready driver, and a cursor predictor running beside it works
// out the draw, scroll and clear words due for each accepted word. A monitor
// compares every result word with the oldest one due. The run covers a
// directed set of characters and cursor moves, then random traffic over a
// range of screen sizes, with random stalls on both sides in most phases.
// ----------------------------------------------------------------------------
module tb_text_terminal_cursor_control;
    import ttcc_pkg::*;

    localparam logic [1:0] CMD_UNDEF = 2'd3;
    localparam int PHASE_COUNT = 9;
    localparam int PHASE_WORDS = 183;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;

    // Predictor state: screen size registers and the cursor.
    logic [8:0] cols_reg = COLS_RESET;
    logic [7:0] rows_reg = ROWS_RESET;
    logic [7:0] cur_col = '0;
    logic [6:0] cur_row = '0;

    t_in_word  cmd_backlog[$];
    t_out_word cell_ops_due[$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_stall = 0;

    text_terminal_cursor_control DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_out_word make_op(input logic [1:0] op, input int col, input int row,
                                          input int glyph);
        t_out_word o;
        o.operation  = op;
        o.cell_col   = col[7:0];
        o.cell_row   = row[6:0];
        o.glyph_code = glyph[6:0];
        o.last       = 1'b0;
        return o;
    endfunction

    // Moves the cursor for one accepted word and queues the cell operations it causes.
    function automatic void advance_cursor(input t_in_word w);
        int ncols, nrows, x, y, n, sc, sr;
        logic [7:0] g;
        t_out_word ops[2];
        ncols = (cols_reg < 1) ? 1 : ((cols_reg > COL_LIM) ? COL_LIM : int'(cols_reg));
        nrows = (rows_reg < 1) ? 1 : ((rows_reg > ROW_LIM) ? ROW_LIM : int'(rows_reg));
        x = cur_col;
        y = cur_row;
        n = 0;
        case (w.command)
            CMD_SET: begin
                sc = w.set_col;
                sr = w.set_row;
                cur_col = 8'((sc > ncols - 1) ? ncols - 1 : sc);
                cur_row = 7'((sr > nrows - 1) ? nrows - 1 : sr);
            end
            CMD_CLEAR: begin
                cur_col = '0;
                cur_row = '0;
                ops[0] = make_op(OP_CLEAR, 0, 0, 0);
                n = 1;
            end
            CMD_PUT: begin
                if (w.char_code == CH_LF) begin
                    y++;
                    x = 0;
                end else if (w.char_code == CH_CR) begin
                    x = 0;
                end else if (w.char_code == CH_BS) begin
                    if (x > 0) begin
                        x--;
                        if (x < ncols && y < nrows) begin
                            ops[n] = make_op(OP_DRAW, x, y, CH_SPACE);
                            n++;
                        end
                    end
                end else if (w.char_code == CH_TAB) begin
                    x = (x / TAB_STOP + 1) * TAB_STOP;
                end else begin
                    g = (w.char_code < PRINT_LO || w.char_code > PRINT_HI) ? CH_QMARK
                                                                           : w.char_code;
                    // A cursor left outside a shrunken screen draws nothing.
                    if (x < ncols && y < nrows) begin
                        ops[n] = make_op(OP_DRAW, x, y, g);
                        n++;
                    end
                    x++;
                end
                if (x >= ncols) begin
                    x = 0;
                    y++;
                end
                if (y >= nrows) begin
                    ops[n] = make_op(OP_SCROLL, 0, 0, 0);
                    n++;
                    y = nrows - 1;
                end
                cur_col = x[7:0];
                cur_row = y[6:0];
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            ops[i].last = (i == n - 1);
            cell_ops_due.push_back(ops[i]);
        end
    endfunction

    // Driver: one word in flight, random gaps only between words.
    always @(posedge i_clk) begin : feed
        logic     nxt_valid;
        t_in_word nxt_word;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            nxt_valid = in_valid;
            nxt_word  = in_word;
            if (in_valid && in_ready) begin
                advance_cursor(in_word);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 17);
                end else if (cmd_backlog.size() > 0) begin
                    nxt_word  = cmd_backlog.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
            in_word  <= nxt_word;
        end
    end

    task automatic check_field(input string nm, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d got %0d", $time, nm, want_v, got_v);
            mismatches++;
        end
    endtask

    // Monitor: checks each accepted result word and stalls at random.
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (cell_ops_due.size() == 0) begin
                    $display("%0t: result word %h expected none", $time, out_word);
                    mismatches++;
                end else begin
                    want = cell_ops_due.pop_front();
                    check_field("operation", 8'(want.operation), 8'(out_word.operation));
                    check_field("cell_col", want.cell_col, out_word.cell_col);
                    check_field("cell_row", 8'(want.cell_row), 8'(out_word.cell_row));
                    check_field("glyph_code", 8'(want.glyph_code), 8'(out_word.glyph_code));
                    check_field("last", 8'(want.last), 8'(out_word.last));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                recv_stall = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_word(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic [7:0] col, input logic [6:0] row);
        t_in_word w;
        w.command   = cmd;
        w.char_code = ch;
        w.set_col   = col;
        w.set_row   = row;
        cmd_backlog.push_back(w);
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        int r, k;
        w.char_code = 8'($urandom);
        w.set_col   = 8'($urandom);
        w.set_row   = 7'($urandom);
        r = $urandom_range(0, 99);
        if (r < 72) begin
            w.command = CMD_PUT;
            k = $urandom_range(0, 11);
            case (k)
                5:       w.char_code = CH_LF;
                6:       w.char_code = CH_CR;
                7:       w.char_code = CH_BS;
                8:       w.char_code = CH_TAB;
                9, 10, 11: ;
                default: w.char_code = 8'($urandom_range(32, 126));
            endcase
        end else if (r < 88) begin
            w.command = CMD_SET;
        end else if (r < 95) begin
            w.command = CMD_CLEAR;
        end else begin
            w.command = CMD_UNDEF;
        end
        return w;
    endfunction

    // Waits until every queued word is in and every result is out, then lets
    // the block finish any word that gives no result.
    task automatic drain_pipeline();
        while (!(cmd_backlog.size() == 0 && !in_valid && cell_ops_due.size() == 0))
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COLUMNS: cols_reg = val[8:0];
            CFG_ROWS:    rows_reg = val[7:0];
            default: ;
        endcase
    endtask

    initial begin
        int c, r, added;
        logic [31:0] val;
        t_in_word w;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words at the reset screen size of 80 by 25.
        queue_word(CMD_CLEAR, 8'h00, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'h41, 8'hFF, 7'h7F);
        queue_word(CMD_PUT, PRINT_LO, 8'h00, 7'h00);
        queue_word(CMD_PUT, PRINT_HI, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'h1F, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'h7F, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'h00, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'hFF, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'h80, 8'h00, 7'h00);
        queue_word(CMD_PUT, CH_TAB, 8'h00, 7'h00);
        queue_word(CMD_PUT, CH_BS, 8'h00, 7'h00);
        queue_word(CMD_PUT, CH_CR, 8'h00, 7'h00);
        // Backspace at column zero does nothing.
        queue_word(CMD_PUT, CH_BS, 8'h00, 7'h00);
        queue_word(CMD_PUT, CH_LF, 8'h00, 7'h00);
        // Cursor set past the screen is clamped to the last cell; a glyph there
        // draws and then wraps into a scroll.
        queue_word(CMD_SET, 8'hFF, 8'hFF, 7'h7F);
        queue_word(CMD_PUT, 8'h78, 8'h00, 7'h00);
        queue_word(CMD_PUT, CH_LF, 8'h00, 7'h00);
        queue_word(CMD_SET, 8'h00, 8'd76, 7'd24);
        queue_word(CMD_PUT, CH_TAB, 8'h00, 7'h00);
        queue_word(CMD_UNDEF, 8'hFF, 8'hFF, 7'h7F);
        queue_word(CMD_SET, 8'h00, 8'h00, 7'h00);
        queue_word(CMD_PUT, 8'h55, 8'hFF, 7'h7F);
        queue_word(CMD_CLEAR, 8'hFF, 8'hFF, 7'h7F);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_pipeline();
            case (ph)
                0:       begin c = 80;  r = 25;  end
                1:       begin c = 1;   r = 1;   end
                2:       begin c = 256; r = 128; end
                3:       begin c = 0;   r = 0;   end
                4:       begin c = 511; r = 255; end
                5:       begin c = 10;  r = 5;   end
                6:       begin c = 40;  r = 12;  end
                7:       begin c = 3;   r = 2;   end
                default: begin c = $urandom_range(1, 60); r = $urandom_range(1, 20); end
            endcase
            // Upper data bits carry junk; only the register width counts.
            val = $urandom;
            val[8:0] = c[8:0];
            write_reg(CFG_COLUMNS, val);
            val = $urandom;
            val[7:0] = r[7:0];
            write_reg(CFG_ROWS, val);
            write_reg(CFG_FG, (ph == 1) ? 32'h0 : ((ph == 2) ? 32'hFFFF_FFFF : $urandom));
            write_reg(CFG_BG, (ph == 1) ? 32'hFFFF_FFFF : ((ph == 2) ? 32'h0 : $urandom));

            if (ph % 3 == 2 || ph == PHASE_COUNT - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(5, 35);
                recv_idle_pct = $urandom_range(5, 35);
            end

            @(negedge i_clk);
            added = 0;
            while (added < PHASE_WORDS) begin
                w = random_word();
                cmd_backlog.push_back(w);
                added++;
            end
            // Park the cursor in the far corner so a smaller next screen
            // leaves it outside.
            queue_word(CMD_SET, 8'h00, 8'hFF, 7'h7F);
        end

        drain_pipeline();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && cell_ops_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ttcc_pkg.sv
rtl/ttcc_step.sv
rtl/text_terminal_cursor_control.sv
bench/tb_text_terminal_cursor_control.sv
